[design/plia_pkg.sv]
// ----------------------------------------------------------------------------
// plia_pkg
// Shared widths, limits and the sequencer state type of the interval
// average block.
// ----------------------------------------------------------------------------
`default_nettype none

package plia_pkg;

	localparam int unsigned DEF_MAX_SAMPLES = 512;

	localparam int WL_W  = 16;
	localparam int VAL_W = 24;
	localparam int CFG_W = 10;
	localparam int IDX_IN_W = 9;

	// Shared multiplier operands and product.
	localparam int MUL_A_W = 44;
	localparam int MUL_B_W = 20;
	localparam int PROD_W  = 64;

	localparam int SUM_W = 50;

	// Shared divider.
	localparam int DIV_NUM_W = 63;
	localparam int DIV_DEN_W = 21;

	localparam logic [0:0] CMD_WRITE = 1'b0;
	localparam logic [0:0] CMD_QUERY = 1'b1;

	localparam logic [0:0] STATUS_OK    = 1'b0;
	localparam logic [0:0] STATUS_EMPTY = 1'b1;

	localparam int VAL_MAX = 8388607;
	localparam int VAL_MIN_MAG = 8388608;

	typedef enum logic [19:0] {
		S_IDLE  = 20'h00001,
		S_RD0   = 20'h00002,
		S_RDN   = 20'h00004,
		S_CHK   = 20'h00008,
		S_PRE1  = 20'h00010,
		S_PRE2  = 20'h00020,
		S_PRE3  = 20'h00040,
		S_SRCH  = 20'h00080,
		S_SRCHW = 20'h00100,
		S_SEG0  = 20'h00200,
		S_SEG1  = 20'h00400,
		S_SEG2  = 20'h00800,
		S_MUL1  = 20'h01000,
		S_MUL2  = 20'h02000,
		S_MUL3  = 20'h04000,
		S_MUL4  = 20'h08000,
		S_SDIV  = 20'h10000,
		S_SWAIT = 20'h20000,
		S_FDIV  = 20'h40000,
		S_FWAIT = 20'h80000
	} plia_state_t;

endpackage

`default_nettype wire

[design/plia_ram.sv]
// ----------------------------------------------------------------------------
// plia_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plia_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

[design/plia_div.sv]
// ----------------------------------------------------------------------------
// plia_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plia_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [plia_pkg::DIV_NUM_W-1:0]  num,
	input  wire logic [plia_pkg::DIV_DEN_W-1:0]  den,
	output logic                                 busy,
	output logic                                 done,
	output logic      [plia_pkg::DIV_NUM_W-1:0]  quo
);
	import plia_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   shifted;
	logic                 fits;

	assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DEN_W'(shifted - {1'b0, den_q}) : DIV_DEN_W'(shifted);
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

[design/piecewise_linear_interval_average.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_interval_average
// Average of a piecewise-linear sampled function over a wavelength interval.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. cmd selects a table
// write (sample_index, sample_wavelength, sample_value) or an interval query
// (interval_start, interval_end). A write finishes in the accept cycle, gives
// no result and leaves busy low. A query raises busy and gives one result:
// average and status on the ports for one cycle, marked by done, which the
// receiver must take as it comes.
// An empty or reversed interval leaves busy low and answers in the cycle after
// the accept. Queries outside the table or with one sample in use end after
// RD0, RDN and CHK. Otherwise PRE1 to PRE3 add the parts beyond the end
// samples, a search finds the first segment and each segment that overlaps
// the interval takes three passes through the shared multiplier and one
// through the 63-step serial divider, one that adds no area being skipped;
// done comes in the cycle after the final division. One single-port RAM holds
// the table. sample_count is set over the APB port, by the user only while the
// block is idle, which the block does not enforce. Reset returns sample_count
// to 1 and the sequencer to idle; table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interval_average #(
	parameter int unsigned MAX_SAMPLES = plia_pkg::DEF_MAX_SAMPLES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [1:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic      [31:0]                         prdata,
	output logic                                     pready,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                cmd,
	input  wire logic [plia_pkg::IDX_IN_W-1:0]       sample_index,
	input  wire logic [plia_pkg::WL_W-1:0]           sample_wavelength,
	input  wire logic signed [plia_pkg::VAL_W-1:0]   sample_value,
	input  wire logic [plia_pkg::WL_W-1:0]           interval_start,
	input  wire logic [plia_pkg::WL_W-1:0]           interval_end,
	output logic                                     done,
	output logic signed [plia_pkg::VAL_W-1:0]        average,
	output logic                                     status
);
	import plia_pkg::*;

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int ENT_W = WL_W + VAL_W;

	plia_state_t state_q;

	logic [CFG_W-1:0] sample_count_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] i_q;
	logic [WL_W-1:0]  start_q, end_q;
	logic [WL_W-1:0]  f_wl_q, s_l0_q;
	logic signed [VAL_W-1:0] f_v_q, s_v0_q;
	logic [WL_W-1:0]  d_q, w_q;
	logic [WL_W:0]    asum_q;
	logic signed [VAL_W:0] dv_q;
	logic signed [MUL_A_W-1:0] num_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic done_q, status_q;
	logic signed [VAL_W-1:0] average_q;
	logic [WL_W-1:0] l_wl_q;
	logic signed [VAL_W-1:0] rd_v_last_q;

	logic accept, cfg_wr, ram_we;
	logic [IDX_W-1:0] ram_addr;
	logic [ENT_W-1:0] ram_rdata;
	logic [WL_W-1:0]  rd_wl;
	logic signed [VAL_W-1:0] rd_v;
	logic [31:0] n_full;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;

	logic signed [WL_W:0] seg_d;
	logic [WL_W-1:0] seg_x0, seg_x1;
	logic seg_ok;

	logic [PROD_W-1:0] prod_mag;
	logic [SUM_W-1:0]  sum_mag;
	logic [WL_W-1:0]   int_w;

	logic div_start, div_busy, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic [DIV_DEN_W-1:0] div_den;
	logic signed [SUM_W-1:0] quo_s;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = 32'(sample_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= CFG_W'(1);
		end else if (cfg_wr) begin
			sample_count_q <= pwdata[CFG_W-1:0];
		end
	end

	assign busy   = !(state_q == S_IDLE);
	assign accept = start && !busy;
	assign ram_we = accept && cmd == CMD_WRITE && 32'(sample_index) < MAX_SAMPLES;

	assign n_full = (sample_count_q == '0) ? 32'd1 :
		(32'(sample_count_q) > MAX_SAMPLES) ? 32'(MAX_SAMPLES) : 32'(sample_count_q);

	always_comb begin
		case (state_q)
			S_IDLE:  ram_addr = IDX_W'(sample_index);
			S_RDN:   ram_addr = IDX_W'(n_q - 1'b1);
			S_SRCH:  ram_addr = IDX_W'(i_q + 1'b1);
			S_SEG0:  ram_addr = i_q;
			S_SEG1:  ram_addr = IDX_W'(i_q + 1'b1);
			default: ram_addr = '0;
		endcase
	end

	plia_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SAMPLES)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({sample_wavelength, sample_value}),
		.rdata (ram_rdata)
	);

	assign rd_wl = ram_rdata[ENT_W-1:VAL_W];
	assign rd_v  = signed'(ram_rdata[VAL_W-1:0]);

	// Clipping of the segment just read against the query interval.
	assign seg_d  = signed'({1'b0, rd_wl}) - signed'({1'b0, s_l0_q});
	assign seg_x0 = (start_q > s_l0_q) ? start_q : s_l0_q;
	assign seg_x1 = (end_q < rd_wl) ? end_q : rd_wl;
	assign seg_ok = (seg_d > 0) && (seg_x1 > seg_x0);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PRE1: begin
				mul_a = MUL_A_W'(f_v_q);
				mul_b = (start_q < f_wl_q) ? signed'(MUL_B_W'(f_wl_q - start_q)) : '0;
			end
			S_PRE2: begin
				mul_a = MUL_A_W'(rd_v_last_q);
				mul_b = (end_q > l_wl_q) ? signed'(MUL_B_W'(end_q - l_wl_q)) : '0;
			end
			S_MUL1: begin
				mul_a = MUL_A_W'(s_v0_q);
				mul_b = signed'(MUL_B_W'(d_q));
			end
			S_MUL2: begin
				mul_a = MUL_A_W'(dv_q);
				mul_b = signed'(MUL_B_W'(asum_q));
			end
			S_MUL4: begin
				mul_a = num_q;
				mul_b = signed'(MUL_B_W'(w_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign int_w    = end_q - start_q;
	assign quo_s    = signed'(SUM_W'(div_quo));

	// Rounding to nearest: half the divisor is added to the magnitude first.
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		if (state_q == S_SDIV) begin
			div_start = 1'b1;
			div_num   = DIV_NUM_W'({prod_mag, 4'b0000}) + DIV_NUM_W'(d_q);
			div_den   = DIV_DEN_W'({d_q, 1'b0});
		end else if (state_q == S_FDIV) begin
			div_start = 1'b1;
			div_num   = DIV_NUM_W'(sum_mag) + DIV_NUM_W'({int_w, 3'b000});
			div_den   = DIV_DEN_W'({int_w, 4'b0000});
		end
	end

	plia_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic neg_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && cmd == CMD_QUERY) begin
						if (interval_end <= interval_start) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_RD0;
						end
					end
				end
				S_RD0:  state_q <= S_RDN;
				S_RDN:  state_q <= S_CHK;
				S_CHK: begin
					if (end_q <= f_wl_q || start_q >= rd_wl || n_q == CNT_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PRE1;
					end
				end
				S_PRE1: state_q <= S_PRE2;
				S_PRE2: state_q <= S_PRE3;
				S_PRE3: state_q <= S_SRCH;
				S_SRCH: begin
					if (32'(i_q) + 32'd2 < 32'(n_q)) begin
						state_q <= S_SRCHW;
					end else begin
						state_q <= S_SEG0;
					end
				end
				S_SRCHW: state_q <= (start_q > rd_wl) ? S_SRCH : S_SEG0;
				S_SEG0: state_q <= (32'(i_q) + 32'd1 < 32'(n_q)) ? S_SEG1 : S_FDIV;
				S_SEG1: state_q <= (end_q >= rd_wl) ? S_SEG2 : S_FDIV;
				S_SEG2: state_q <= seg_ok ? S_MUL1 : S_SEG0;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_MUL4;
				S_MUL4: state_q <= S_SDIV;
				S_SDIV: state_q <= S_SWAIT;
				S_SWAIT: begin
					if (div_done) begin
						state_q <= S_SEG0;
					end
				end
				S_FDIV: state_q <= S_FWAIT;
				S_FWAIT: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				start_q   <= interval_start;
				end_q     <= interval_end;
				n_q       <= CNT_W'(n_full);
				status_q  <= STATUS_EMPTY;
				average_q <= '0;
			end
			S_RDN: begin
				f_wl_q <= rd_wl;
				f_v_q  <= rd_v;
			end
			S_CHK: begin
				l_wl_q      <= rd_wl;
				rd_v_last_q <= rd_v;
				status_q    <= STATUS_OK;
				if (end_q <= f_wl_q) begin
					average_q <= f_v_q;
				end else if (start_q >= rd_wl) begin
					average_q <= rd_v;
				end else begin
					average_q <= f_v_q;
				end
			end
			S_PRE1: prod_q <= mul_a * mul_b;
			S_PRE2: begin
				sum_q  <= SUM_W'(prod_q) <<< 4;
				prod_q <= mul_a * mul_b;
			end
			S_PRE3: begin
				sum_q <= sum_q + (SUM_W'(prod_q) <<< 4);
				i_q   <= '0;
			end
			S_SRCHW: begin
				if (start_q > rd_wl) begin
					i_q <= i_q + 1'b1;
				end
			end
			S_SEG1: begin
				s_l0_q <= rd_wl;
				s_v0_q <= rd_v;
			end
			S_SEG2: begin
				d_q    <= WL_W'(seg_d);
				w_q    <= seg_x1 - seg_x0;
				asum_q <= (WL_W + 1)'(seg_x0 - s_l0_q) + (WL_W + 1)'(seg_x1 - s_l0_q);
				dv_q   <= (VAL_W + 1)'(rd_v) - (VAL_W + 1)'(s_v0_q);
				if (!seg_ok) begin
					i_q <= i_q + 1'b1;
				end
			end
			S_MUL1: prod_q <= mul_a * mul_b;
			S_MUL2: begin
				num_q  <= MUL_A_W'(prod_q) <<< 1;
				prod_q <= mul_a * mul_b;
			end
			S_MUL3: num_q <= num_q + MUL_A_W'(prod_q);
			S_MUL4: prod_q <= mul_a * mul_b;
			S_SDIV: neg_q <= prod_q[PROD_W-1];
			S_SWAIT: begin
				if (div_done) begin
					sum_q <= neg_q ? sum_q - quo_s : sum_q + quo_s;
					i_q   <= i_q + 1'b1;
				end
			end
			S_FDIV: neg_q <= sum_q[SUM_W-1];
			S_FWAIT: begin
				if (div_done) begin
					if (!neg_q && div_quo > DIV_NUM_W'(VAL_MAX)) begin
						average_q <= VAL_W'(VAL_MAX);
					end else if (neg_q && div_quo > DIV_NUM_W'(VAL_MIN_MAG)) begin
						average_q <= VAL_W'(VAL_MIN_MAG);
					end else begin
						average_q <= neg_q ? -signed'(VAL_W'(div_quo))
							: signed'(VAL_W'(div_quo));
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done    = done_q;
	assign average = average_q;
	assign status  = status_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_EMPTY) |-> average == '0)
		else $error("empty interval with nonzero average");

	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(cmd) == CMD_QUERY)
		else $error("busy raised without a query request");

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the piecewise-linear interval average block.
// Table writes and interval queries flow through a bursty command driver.
// A built-in predictor tracks the sample table and sample_count and
// computes each expected average. A monitor checks every done strobe
// against the oldest pending expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import plia_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int        TABLE_DEPTH      = 512;
	localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
	localparam int        SETTLE_CYCLES    = 100;

	typedef struct {
		logic [0:0]              cmd;
		logic [IDX_IN_W-1:0]     idx;
		logic [WL_W-1:0]         wl;
		logic signed [VAL_W-1:0] val;
		logic [WL_W-1:0]         lo;
		logic [WL_W-1:0]         hi;
	} request_t;

	typedef struct {
		logic signed [VAL_W-1:0] average;
		logic [0:0]              status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic cmd = CMD_WRITE;
	logic [IDX_IN_W-1:0] sample_index = '0;
	logic [WL_W-1:0] sample_wavelength = '0;
	logic signed [VAL_W-1:0] sample_value = '0;
	logic [WL_W-1:0] interval_start = '0;
	logic [WL_W-1:0] interval_end = '0;
	logic done;
	logic signed [VAL_W-1:0] average;
	logic status;

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	request_t cur_req;
	int       mismatches = 0;

	// Predictor state, updated as requests are accepted.
	longint wl_tab[TABLE_DEPTH];
	longint val_tab[TABLE_DEPTH];
	int     cfg_count = 1;

	// Plan state, updated as requests are queued.
	int plan_wl[TABLE_DEPTH];

	int burst_left = 0;
	int gap_left = 0;

	piecewise_linear_interval_average u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .cmd(cmd),
		.sample_index(sample_index), .sample_wavelength(sample_wavelength),
		.sample_value(sample_value), .interval_start(interval_start),
		.interval_end(interval_end),
		.done(done), .average(average), .status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint round_div(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint trap_area(int k, longint lo, longint hi);
		longint l0, l1, v0, v1, d, x0, x1, num;
		l0 = wl_tab[k];
		l1 = wl_tab[k + 1];
		v0 = val_tab[k];
		v1 = val_tab[k + 1];
		d = l1 - l0;
		x0 = (lo > l0) ? lo : l0;
		x1 = (hi < l1) ? hi : l1;
		if (d <= 0 || x1 <= x0)
			return 0;
		num = 2 * v0 * d + (v1 - v0) * ((x0 - l0) + (x1 - l0));
		return round_div(num * (x1 - x0) * 16, 2 * d);
	endfunction

	function automatic answer_t interval_mean(logic [WL_W-1:0] lo_w, logic [WL_W-1:0] hi_w);
		longint s, e, acc, q;
		int n, k;
		answer_t r;
		s = longint'(lo_w);
		e = longint'(hi_w);
		r.status = STATUS_OK;
		if (e <= s) begin
			r.average = '0;
			r.status = STATUS_EMPTY;
			return r;
		end
		n = cfg_count;
		if (n < 1)
			n = 1;
		if (n > TABLE_DEPTH)
			n = TABLE_DEPTH;
		if (e <= wl_tab[0]) begin
			q = val_tab[0];
		end else if (s >= wl_tab[n - 1]) begin
			q = val_tab[n - 1];
		end else if (n == 1) begin
			q = val_tab[0];
		end else begin
			acc = 0;
			if (s < wl_tab[0])
				acc += val_tab[0] * (wl_tab[0] - s) * 16;
			if (e > wl_tab[n - 1])
				acc += val_tab[n - 1] * (e - wl_tab[n - 1]) * 16;
			k = 0;
			while (k + 2 < n && s > wl_tab[k + 1])
				k++;
			for (; k + 1 < n && e >= wl_tab[k]; k++)
				acc += trap_area(k, s, e);
			q = round_div(acc, (e - s) * 16);
			if (q > VAL_MAX)
				q = VAL_MAX;
			if (q < -longint'(VAL_MIN_MAG))
				q = -longint'(VAL_MIN_MAG);
		end
		r.average = q[VAL_W-1:0];
		return r;
	endfunction

	function automatic void apply_request(request_t r);
		if (r.cmd == CMD_WRITE) begin
			wl_tab[r.idx] = longint'(r.wl);
			val_tab[r.idx] = longint'(r.val);
		end else begin
			expected_answers.push_back(interval_mean(r.lo, r.hi));
		end
	endfunction

	// Command driver: start stays high until the request is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && busy) begin
				// hold the current request
			end else begin
				if (start)
					apply_request(cur_req);
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					cmd <= cur_req.cmd;
					sample_index <= cur_req.idx;
					sample_wavelength <= cur_req.wl;
					sample_value <= cur_req.val;
					interval_start <= cur_req.lo;
					interval_end <= cur_req.hi;
					start <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Result monitor.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected result, average", longint'(average), 0);
			end else begin
				want = expected_answers.pop_front();
				if (average !== want.average)
					report_mismatch("average", longint'(average), longint'(want.average));
				if (status !== want.status)
					report_mismatch("status", longint'(status), longint'(want.status));
			end
		end
	end

	task automatic queue_write(int idx, int wl, int val);
		request_t r;
		r.cmd = CMD_WRITE;
		r.idx = IDX_IN_W'(idx);
		r.wl = WL_W'(wl);
		r.val = VAL_W'(val);
		r.lo = WL_W'($urandom);
		r.hi = WL_W'($urandom);
		plan_wl[r.idx] = int'(r.wl);
		pending_requests.push_back(r);
	endtask

	task automatic queue_query(int lo, int hi);
		request_t r;
		r.cmd = CMD_QUERY;
		r.idx = IDX_IN_W'($urandom);
		r.wl = WL_W'($urandom);
		r.val = VAL_W'($urandom);
		r.lo = WL_W'(lo);
		r.hi = WL_W'(hi);
		pending_requests.push_back(r);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_requests.size() > 0 || start || expected_answers.size() > 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_sample_count(int value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_SAMPLE_COUNT;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_count = value & 32'h3FF;
	endtask

	// Fills entries 0..n-1; a messy table has repeats and reversals.
	task automatic fill_table(int n, int step_max, bit messy);
		int wl, k;
		wl = $urandom_range(0, 20000);
		for (k = 0; k < n; k++) begin
			queue_write(k, wl, $urandom);
			if (messy && $urandom_range(0, 2) == 0)
				wl = $urandom_range(0, 65535);
			else
				wl += $urandom_range(1, step_max);
			if (wl > 65535)
				wl = 65535;
		end
	endtask

	task automatic random_phase(int count_value, int n_items);
		int eff, lo, hi, s, e, k, t;
		set_sample_count(count_value);
		eff = count_value == 0 ? 1 : (count_value > TABLE_DEPTH ? TABLE_DEPTH : count_value);
		fill_table(eff, 4000, $urandom_range(0, 4) == 0);
		for (k = 0; k < n_items; k++) begin
			t = $urandom_range(0, 99);
			lo = plan_wl[0];
			hi = plan_wl[eff - 1];
			if (hi < lo) begin
				s = lo;
				lo = hi;
				hi = s;
			end
			if (t < 8) begin
				// Value-only rewrite keeps the table well formed.
				s = $urandom_range(0, eff - 1);
				queue_write(s, plan_wl[s], $urandom);
			end else if (t < 12) begin
				queue_write($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
			end else if (t < 20) begin
				queue_query($urandom, $urandom);
			end else begin
				s = $urandom_range(lo > 600 ? lo - 600 : 0, hi + 600 > 65535 ? 65535 : hi + 600);
				e = $urandom_range(lo > 600 ? lo - 600 : 0, hi + 600 > 65535 ? 65535 : hi + 600);
				if (t < 90 && e < s) begin
					lo = s;
					s = e;
					e = lo;
				end
				if (t == 99)
					e = s;
				queue_query(s, e);
			end
		end
	endtask

	initial begin
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single sample at reset count, empty and reversed intervals.
		queue_write(0, 1000, 24'h123456);
		queue_query(0, 65535);
		queue_query(500, 500);
		queue_query(900, 100);
		queue_query(0, 1);
		queue_query(65534, 65535);

		// Three samples at the value extremes.
		set_sample_count(3);
		queue_write(0, 0, -8388608);
		queue_write(1, 32768, 8388607);
		queue_write(2, 65535, -8388608);
		queue_query(0, 65535);
		queue_query(100, 200);
		queue_query(32000, 33000);
		queue_query(40000, 40001);
		set_sample_count(3);
		queue_write(0, 2000, 65536);
		queue_write(1, 3000, -65536);
		queue_write(2, 3000, 131072);
		queue_query(0, 1500);
		queue_query(4000, 9000);
		queue_query(1000, 5000);
		queue_query(2500, 3000);
		queue_query(2999, 3001);

		random_phase(0, 40);
		random_phase(1, 40);
		for (k = 0; k < 12; k++)
			random_phase($urandom_range(2, 10), 45);
		random_phase(2, 60);
		random_phase(10, 60);

		// Full table, then a count past the table size.
		set_sample_count(TABLE_DEPTH);
		for (k = 0; k < TABLE_DEPTH; k++)
			queue_write(k, k * 128 + $urandom_range(0, 100), $urandom);
		queue_query(0, 65535);
		queue_query(30000, 30500);
		queue_query(65400, 65535);
		set_sample_count(1023);
		queue_query(0, 65535);
		queue_query(1000, 1300);
		queue_query(65500, 65535);

		wait_idle();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
design/plia_pkg.sv
design/plia_ram.sv
design/plia_div.sv
design/piecewise_linear_interval_average.sv
test/tb_top.sv
